@@ hw/rtl/pidcaw_pkg.sv @@
// Shared widths, control-word types and microcode for the clamped PID controller.
`default_nettype none

package pidcaw_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int LEVEL_W  = 18;
    localparam int ERR_W    = 19;
    localparam int DIFF_W   = 20;
    localparam int DRIVE_W  = 17;
    localparam int GAIN_W   = 32;
    localparam int PER_W    = 24;
    localparam int INT_W    = 40;
    localparam int DER_W    = 36;
    localparam int SPLIT_W  = 20;
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 25;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 72;
    localparam int TERM_SAT = 36;
    localparam int TERM_W   = TERM_SAT + 2;
    localparam int SUM_W    = 40;
    localparam int DER_SHIFT = 8;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;
    localparam int M_PAD_W  = M_DATA_W - DRIVE_W - ERR_W;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_SETPOINT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INV_PER  = 3'd5;

    localparam logic [PER_W-1:0] PERIOD_RESET  = 24'd65536;
    localparam logic [PER_W-1:0] INV_PER_RESET = 24'd256;

    typedef enum logic [2:0] {
        MUL_ESP,
        MUL_DIP,
        MUL_GPE,
        MUL_GIH,
        MUL_GIL,
        MUL_GDH,
        MUL_GDL
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_LOAD_HI,
        ACC_ADD
    } t_acc_op;

    typedef enum logic [1:0] {
        SUM_NONE,
        SUM_LOAD,
        SUM_ADD
    } t_sum_op;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_IN_WAIT,
        COND_OUT_BUSY
    } t_cond;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] ST_TAKE    = 4'd0;
    localparam logic [STEP_W-1:0] ST_MUL_ESP = 4'd1;
    localparam logic [STEP_W-1:0] ST_INT     = 4'd2;
    localparam logic [STEP_W-1:0] ST_DER     = 4'd3;
    localparam logic [STEP_W-1:0] ST_ACC_P   = 4'd4;
    localparam logic [STEP_W-1:0] ST_TERM_P  = 4'd5;
    localparam logic [STEP_W-1:0] ST_ACC_I   = 4'd6;
    localparam logic [STEP_W-1:0] ST_TERM_I  = 4'd7;
    localparam logic [STEP_W-1:0] ST_ACC_D   = 4'd8;
    localparam logic [STEP_W-1:0] ST_TERM_D  = 4'd9;
    localparam logic [STEP_W-1:0] ST_FINISH  = 4'd10;

    typedef struct packed {
        t_mul_sel          mul_sel;
        t_acc_op           acc_op;
        t_sum_op           sum_op;
        logic              int_upd;
        logic              der_upd;
        logic              take;
        logic              finish;
        t_cond             cond;
        logic [STEP_W-1:0] next_step;
    } t_uop;

    function automatic t_uop f_ucode(input logic [STEP_W-1:0] step);
        t_uop w;
        w.mul_sel   = MUL_ESP;
        w.acc_op    = ACC_NONE;
        w.sum_op    = SUM_NONE;
        w.int_upd   = 1'b0;
        w.der_upd   = 1'b0;
        w.take      = 1'b0;
        w.finish    = 1'b0;
        w.cond      = COND_NONE;
        w.next_step = step + 1'b1;
        case (step)
            ST_TAKE: begin
                w.take = 1'b1;
                w.cond = COND_IN_WAIT;
            end
            ST_MUL_ESP: begin
                w.mul_sel = MUL_ESP;
            end
            ST_INT: begin
                w.mul_sel = MUL_DIP;
                w.int_upd = 1'b1;
            end
            ST_DER: begin
                w.mul_sel = MUL_GPE;
                w.der_upd = 1'b1;
            end
            ST_ACC_P: begin
                w.mul_sel = MUL_GIH;
                w.acc_op  = ACC_LOAD;
            end
            ST_TERM_P: begin
                w.mul_sel = MUL_GIL;
                w.acc_op  = ACC_LOAD_HI;
                w.sum_op  = SUM_LOAD;
            end
            ST_ACC_I: begin
                w.mul_sel = MUL_GDH;
                w.acc_op  = ACC_ADD;
            end
            ST_TERM_I: begin
                w.mul_sel = MUL_GDL;
                w.acc_op  = ACC_LOAD_HI;
                w.sum_op  = SUM_ADD;
            end
            ST_ACC_D: begin
                w.acc_op = ACC_ADD;
            end
            ST_TERM_D: begin
                w.sum_op = SUM_ADD;
            end
            ST_FINISH: begin
                w.finish    = 1'b1;
                w.cond      = COND_OUT_BUSY;
                w.next_step = ST_TAKE;
            end
            default: begin
                w.next_step = ST_TAKE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pidcaw_seq.sv @@
// Microcode sequencer: step counter, control-word table and wait conditions.
`default_nettype none

module pidcaw_seq
    import pidcaw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_busy,
    output t_uop      o_uop,
    output logic      o_exec,
    output logic      o_in_ready
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    assign o_uop = f_ucode(r_step);

    always_comb begin
        case (o_uop.cond)
            COND_NONE:     o_exec = 1'b1;
            COND_IN_WAIT:  o_exec = i_in_valid;
            COND_OUT_BUSY: o_exec = !i_out_busy;
            default:       o_exec = 1'b1;
        endcase
    end

    assign o_in_ready = (o_uop.cond == COND_IN_WAIT);

    always_comb begin
        n_step = o_exec ? o_uop.next_step : r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_TAKE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/pidcaw_datapath.sv @@
// Datapath with one shared multiplier, accumulator and controller state.
`default_nettype none

module pidcaw_datapath
    import pidcaw_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_uop                      i_uop,
    input  wire logic                      i_exec,
    input  wire logic [LEVEL_W-1:0]        i_level,
    input  wire logic [LEVEL_W-1:0]        i_setpoint,
    input  wire logic signed [GAIN_W-1:0]  i_gain_p,
    input  wire logic signed [GAIN_W-1:0]  i_gain_i,
    input  wire logic signed [GAIN_W-1:0]  i_gain_d,
    input  wire logic [PER_W-1:0]          i_period,
    input  wire logic [PER_W-1:0]          i_inv_period,
    output logic [DRIVE_W-1:0]             o_drive,
    output logic signed [ERR_W-1:0]        o_err,
    output logic                           o_integrating
);

    localparam int FRAC_BITS = FRAC_BITS_DEF;
    localparam int DRV_W     = FRAC_BITS + 1;
    localparam int INT_SUM_W = PROD_W + 1;

    localparam logic signed [INT_SUM_W-1:0] INT_HI =
        (INT_SUM_W'(1) <<< (INT_W - 1)) - INT_SUM_W'(1);
    localparam logic signed [INT_SUM_W-1:0] INT_LO = -(INT_SUM_W'(1) <<< (INT_W - 1));
    localparam logic signed [ACC_W-1:0] TLIM_HI = ACC_W'(1) <<< TERM_SAT;
    localparam logic signed [ACC_W-1:0] TLIM_LO = -(ACC_W'(1) <<< TERM_SAT);
    localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(1) <<< FRAC_BITS;
    localparam logic [DRV_W-1:0] ONE_D = DRV_W'(1) << FRAC_BITS;

    logic signed [ERR_W-1:0]     r_err;
    logic signed [ERR_W-1:0]     r_prev_err;
    logic [DRV_W-1:0]            r_prev_drive;
    logic signed [INT_W-1:0]     r_integ;
    logic signed [DER_W-1:0]     r_deriv;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [SUM_W-1:0]     r_sum;
    logic                        r_integrating;

    logic signed [ERR_W-1:0]     n_err;
    logic signed [DIFF_W-1:0]    err_diff;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [SPLIT_W-1:0]   integ_hi;
    logic signed [DER_W-SPLIT_W-1:0] deriv_hi;
    logic signed [PROD_W-1:0]    prod_sh;
    logic signed [INT_SUM_W-1:0] int_sum;
    logic signed [INT_W-1:0]     int_sat;
    logic signed [ACC_W-1:0]     acc_sh;
    logic signed [TERM_W-1:0]    term;
    logic [DRV_W-1:0]            drive_c;

    assign n_err    = $signed({1'b0, i_setpoint}) - $signed({1'b0, i_level});
    assign err_diff = DIFF_W'(r_err) - DIFF_W'(r_prev_err);
    assign integ_hi = r_integ[INT_W-1:SPLIT_W];
    assign deriv_hi = r_deriv[DER_W-1:SPLIT_W];

    always_comb begin
        case (i_uop.mul_sel)
            MUL_ESP: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = $signed({1'b0, i_period});
            end
            MUL_DIP: begin
                mul_a = MUL_A_W'(err_diff);
                mul_b = $signed({1'b0, i_inv_period});
            end
            MUL_GPE: begin
                mul_a = i_gain_p;
                mul_b = MUL_B_W'(r_err);
            end
            MUL_GIH: begin
                mul_a = i_gain_i;
                mul_b = MUL_B_W'(integ_hi);
            end
            MUL_GIL: begin
                mul_a = i_gain_i;
                mul_b = $signed({{(MUL_B_W-SPLIT_W){1'b0}}, r_integ[SPLIT_W-1:0]});
            end
            MUL_GDH: begin
                mul_a = i_gain_d;
                mul_b = MUL_B_W'(deriv_hi);
            end
            MUL_GDL: begin
                mul_a = i_gain_d;
                mul_b = $signed({{(MUL_B_W-SPLIT_W){1'b0}}, r_deriv[SPLIT_W-1:0]});
            end
            default: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = $signed({1'b0, i_period});
            end
        endcase
    end

    always_comb begin
        prod_sh = r_prod >>> FRAC_BITS;
        int_sum = INT_SUM_W'(r_integ) + INT_SUM_W'(prod_sh);
        if (int_sum > INT_HI) begin
            int_sat = INT_W'(INT_HI);
        end else if (int_sum < INT_LO) begin
            int_sat = INT_W'(INT_LO);
        end else begin
            int_sat = int_sum[INT_W-1:0];
        end
    end

    always_comb begin
        acc_sh = r_acc >>> FRAC_BITS;
        if (acc_sh > TLIM_HI) begin
            term = TERM_W'(TLIM_HI);
        end else if (acc_sh < TLIM_LO) begin
            term = TERM_W'(TLIM_LO);
        end else begin
            term = acc_sh[TERM_W-1:0];
        end
    end

    always_comb begin
        if (r_sum < 0) begin
            drive_c = '0;
        end else if (r_sum > ONE_S) begin
            drive_c = ONE_D;
        end else begin
            drive_c = r_sum[DRV_W-1:0];
        end
    end

    assign o_drive       = DRIVE_W'(drive_c);
    assign o_err         = r_err;
    assign o_integrating = r_integrating;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_exec && i_uop.take) begin
            r_err <= n_err;
        end
        if (i_exec && i_uop.der_upd) begin
            r_deriv <= DER_W'(r_prod >>> DER_SHIFT);
        end
        case (i_uop.acc_op)
            ACC_NONE:    r_acc <= r_acc;
            ACC_LOAD:    r_acc <= ACC_W'(r_prod);
            ACC_LOAD_HI: r_acc <= ACC_W'(r_prod) <<< SPLIT_W;
            ACC_ADD:     r_acc <= r_acc + ACC_W'(r_prod);
            default:     r_acc <= r_acc;
        endcase
        case (i_uop.sum_op)
            SUM_NONE: r_sum <= r_sum;
            SUM_LOAD: r_sum <= SUM_W'(term);
            SUM_ADD:  r_sum <= r_sum + SUM_W'(term);
            default:  r_sum <= r_sum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err    <= '0;
            r_prev_drive  <= '0;
            r_integ       <= '0;
            r_integrating <= 1'b0;
        end else begin
            if (i_exec && i_uop.take) begin
                r_integrating <= (r_prev_drive != '0) && (r_prev_drive < ONE_D);
            end
            if (i_exec && i_uop.int_upd && r_integrating) begin
                r_integ <= int_sat;
            end
            if (i_exec && i_uop.finish) begin
                r_prev_err   <= r_err;
                r_prev_drive <= drive_c;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/pid_controller_clamped_antiwindup.sv @@
// Top level of the clamped PID controller with conditional anti-windup.
`default_nettype none

// Each accepted level sample produces one result transaction carrying the clamped
// drive, the control error and a flag that tells whether the integral was updated.
// After the accept step the microcode sequencer runs ten steps to a loaded result
// (the last one waits while the output is busy), and seven of them feed the one
// shared 32 x 25 multiplier that forms the integral increment, the derivative and
// the three gain products. The result sits in an output register, so the next
// sample is accepted as soon as the program returns to its first step, even while
// the previous result still waits. The user must write configuration through the
// APB port only while no sample is in flight; the block does not enforce this.

module pid_controller_clamped_antiwindup
    import pidcaw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [17:0] measured_level
    input  wire logic [S_DATA_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [16:0] drive, [35:17] control_error
    output logic [M_DATA_W-1:0]        m_axis_tdata,
    // [0] integrating
    output logic                       m_axis_tuser,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready
);

    logic [LEVEL_W-1:0]        r_setpoint;
    logic signed [GAIN_W-1:0]  r_gain_p;
    logic signed [GAIN_W-1:0]  r_gain_i;
    logic signed [GAIN_W-1:0]  r_gain_d;
    logic [PER_W-1:0]          r_period;
    logic [PER_W-1:0]          r_inv_period;

    logic                      r_m_valid;
    logic [DRIVE_W-1:0]        r_m_drive;
    logic signed [ERR_W-1:0]   r_m_err;
    logic                      r_m_integ;

    t_uop                      uop;
    logic                      exec;
    logic                      out_busy;
    logic                      cfg_wr;
    logic [REG_IDX_W-1:0]      reg_idx;
    logic [DRIVE_W-1:0]        dp_drive;
    logic signed [ERR_W-1:0]   dp_err;
    logic                      dp_integ;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[APB_AW-1:2];
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_busy = r_m_valid && !m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint   <= '0;
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_period     <= PERIOD_RESET;
            r_inv_period <= INV_PER_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SETPOINT: r_setpoint   <= pwdata[LEVEL_W-1:0];
                REG_GAIN_P:   r_gain_p     <= pwdata;
                REG_GAIN_I:   r_gain_i     <= pwdata;
                REG_GAIN_D:   r_gain_d     <= pwdata;
                REG_PERIOD:   r_period     <= pwdata[PER_W-1:0];
                REG_INV_PER:  r_inv_period <= pwdata[PER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SETPOINT: prdata = APB_DW'(r_setpoint);
            REG_GAIN_P:   prdata = r_gain_p;
            REG_GAIN_I:   prdata = r_gain_i;
            REG_GAIN_D:   prdata = r_gain_d;
            REG_PERIOD:   prdata = APB_DW'(r_period);
            REG_INV_PER:  prdata = APB_DW'(r_inv_period);
            default:      prdata = '0;
        endcase
    end

    pidcaw_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_busy (out_busy),
        .o_uop      (uop),
        .o_exec     (exec),
        .o_in_ready (s_axis_tready)
    );

    pidcaw_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_uop         (uop),
        .i_exec        (exec),
        .i_level       (s_axis_tdata[LEVEL_W-1:0]),
        .i_setpoint    (r_setpoint),
        .i_gain_p      (r_gain_p),
        .i_gain_i      (r_gain_i),
        .i_gain_d      (r_gain_d),
        .i_period      (r_period),
        .i_inv_period  (r_inv_period),
        .o_drive       (dp_drive),
        .o_err         (dp_err),
        .o_integrating (dp_integ)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (exec && uop.finish) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec && uop.finish) begin
            r_m_drive <= dp_drive;
            r_m_err   <= dp_err;
            r_m_integ <= dp_integ;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, r_m_err, r_m_drive};
    assign m_axis_tuser  = r_m_integ;

`ifndef SYNTHESIS
    a_accept_leaves_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sequencer stayed in its wait step after a transaction");

    a_finish_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && uop.finish) |=> m_axis_tvalid)
        else $error("finished sample did not produce a result transaction");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !(exec && uop.finish))
        else $error("pending result overwritten before its transaction");
`endif

endmodule

`default_nettype wire
